>>> sv/rstt_pkg.sv
// Shared definitions for the register and stack taint tracker.
// Holds operation and event codes, default sizes and the control structs.
// No dependencies.
package rstt_pkg;

  localparam int STACK_SLOTS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_MOV    = 4'd3;
  localparam logic [3:0] OP_LOAD   = 4'd4;
  localparam logic [3:0] OP_STORE  = 4'd5;
  localparam logic [3:0] OP_BRANCH = 4'd6;
  localparam logic [3:0] OP_CALL   = 4'd7;
  localparam logic [3:0] OP_RETURN = 4'd8;
  localparam logic [3:0] OP_CBZ    = 4'd9;
  localparam logic [3:0] OP_CBNZ   = 4'd10;
  localparam logic [3:0] OP_OTHER  = 4'd11;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_SOURCE  = 3'd1;
  localparam logic [2:0] EV_STORE   = 3'd2;
  localparam logic [2:0] EV_LOAD    = 3'd3;
  localparam logic [2:0] EV_SPREAD  = 3'd4;
  localparam logic [2:0] EV_SINK    = 3'd5;
  localparam logic [2:0] EV_GENERIC = 3'd6;

  typedef struct packed {
    logic en;
    logic clear;
    logic store;
  } slot_req_t;

  typedef struct packed {
    logic hit;
    logic full;
    logic any;
  } slot_stat_t;

  typedef struct packed {
    logic       activity;
    logic [2:0] event_kind;
    logic       sink_hit;
    logic       slot_overflow;
  } result_t;

endpackage

>>> sv/rstt_slot_table.sv
// Table of tainted stack offsets with per-slot valid bits and parallel match.
// Depends on rstt_pkg for the request and status structs.
module rstt_slot_table #(
  parameter int STACK_SLOTS = rstt_pkg::STACK_SLOTS_DEF,
  parameter int OFFSET_BITS = rstt_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rstt_pkg::slot_req_t    req,
  input  logic [OFFSET_BITS-1:0] offset,
  output rstt_pkg::slot_stat_t   stat
);

  logic [STACK_SLOTS-1:0] valid;
  logic [STACK_SLOTS-1:0] valid_next;
  logic [OFFSET_BITS-1:0] slot_off [STACK_SLOTS];
  logic [STACK_SLOTS-1:0] eff_valid;
  logic [STACK_SLOTS-1:0] free;
  logic [STACK_SLOTS-1:0] first_free;
  logic [STACK_SLOTS-1:0] match;
  logic                   do_write;

  always_comb begin
    eff_valid  = req.clear ? '0 : valid;
    free       = ~eff_valid;
    first_free = free & (~free + {{(STACK_SLOTS-1){1'b0}}, 1'b1});
    for (int i = 0; i < STACK_SLOTS; i++) begin
      match[i] = eff_valid[i] && (slot_off[i] == offset);
    end
    stat.hit   = |match;
    stat.full  = ~|free;
    do_write   = req.store && !stat.hit && !stat.full;
    valid_next = eff_valid | (do_write ? first_free : '0);
    stat.any   = |valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.en) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STACK_SLOTS; i++) begin
      if (req.en && do_write && first_free[i]) begin
        slot_off[i] <= offset;
      end
    end
  end

endmodule

>>> sv/rstt_propagate.sv
// Taint propagation rules for one instruction over the register mask.
// Depends on rstt_pkg for codes and structs; uses slot status from the table.
module rstt_propagate (
  input  logic [3:0]           op_kind,
  input  logic signed [5:0]    dest_reg,
  input  logic signed [5:0]    first_src_reg,
  input  logic signed [5:0]    second_src_reg,
  input  logic                 call_is_source,
  input  logic [31:0]          mask_in,
  input  logic                 sink_in,
  input  rstt_pkg::slot_stat_t stat,
  output logic                 store_req,
  output logic [31:0]          mask_out,
  output logic                 sink_out,
  output rstt_pkg::result_t    res
);

  logic dst_t;
  logic s1_t;
  logic s2_t;
  logic dst_ok;

  always_comb begin
    dst_ok = !dest_reg[5];
    dst_t  = dst_ok && mask_in[dest_reg[4:0]];
    s1_t   = !first_src_reg[5] && mask_in[first_src_reg[4:0]];
    s2_t   = !second_src_reg[5] && mask_in[second_src_reg[4:0]];

    mask_out  = mask_in;
    sink_out  = sink_in;
    store_req = 1'b0;
    res       = '0;

    case (op_kind)
      rstt_pkg::OP_CALL: begin
        if (call_is_source) begin
          mask_out[0]    = 1'b1;
          res.activity   = 1'b1;
          res.event_kind = rstt_pkg::EV_SOURCE;
        end
      end
      rstt_pkg::OP_STORE: begin
        if (dst_t) begin
          store_req         = 1'b1;
          res.activity      = 1'b1;
          res.event_kind    = rstt_pkg::EV_STORE;
          res.slot_overflow = !stat.hit && stat.full;
        end
      end
      rstt_pkg::OP_LOAD: begin
        if (stat.hit) begin
          if (dst_ok) begin
            mask_out[dest_reg[4:0]] = 1'b1;
          end
          res.activity   = 1'b1;
          res.event_kind = rstt_pkg::EV_LOAD;
        end
      end
      rstt_pkg::OP_ADD, rstt_pkg::OP_SUB, rstt_pkg::OP_MOV: begin
        if (dst_ok && (s1_t || s2_t)) begin
          mask_out[dest_reg[4:0]] = 1'b1;
          res.activity            = 1'b1;
          res.event_kind          = rstt_pkg::EV_SPREAD;
        end
      end
      rstt_pkg::OP_RETURN: begin
        if (mask_in[0]) begin
          sink_out       = 1'b1;
          res.sink_hit   = 1'b1;
          res.activity   = 1'b1;
          res.event_kind = rstt_pkg::EV_SINK;
        end
      end
      rstt_pkg::OP_OTHER: begin
        if (dst_ok && s1_t) begin
          mask_out[dest_reg[4:0]] = 1'b1;
          res.activity            = 1'b1;
          res.event_kind          = rstt_pkg::EV_GENERIC;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/register_stack_taint_tracker.sv
// Top level of the register and stack taint tracker: input register, rules,
// state and result register. Depends on rstt_pkg, rstt_slot_table, rstt_propagate.
//
//   channel | signals                          | direction
//   in      | in_valid, in_ready, instruction  | into block
//   out     | out_valid, out_ready, result     | out of block
//
// One transaction per cycle sustained while the output is not stalled; an accepted item
// passes through the input register and then the result register.
// The mask, sink flag and slot table update as an item moves into the result
// register, so the next item sees them at once. Reset clears all valid bits.
// A stalled output holds the result register and the item in the input register.
module register_stack_taint_tracker #(
  parameter int STACK_SLOTS = rstt_pkg::STACK_SLOTS_DEF,
  parameter int OFFSET_BITS = rstt_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op_kind,
  input  logic signed [5:0]  dest_reg,
  input  logic signed [5:0]  first_src_reg,
  input  logic signed [5:0]  second_src_reg,
  input  logic signed [15:0] stack_offset,
  input  logic               call_is_source,
  input  logic               start_of_run,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               activity,
  output logic [2:0]         event_kind,
  output logic               sink_hit,
  output logic               sink_seen,
  output logic [31:0]        register_taint,
  output logic               any_slot_tainted,
  output logic               slot_overflow
);

  logic                   hold_valid;
  logic [3:0]             q_kind;
  logic signed [5:0]      q_dst;
  logic signed [5:0]      q_s1;
  logic signed [5:0]      q_s2;
  logic [OFFSET_BITS-1:0] q_off;
  logic                   q_is_src;
  logic                   q_start;

  logic [31:0]            mask;
  logic [31:0]            mask_next;
  logic                   sink;
  logic                   sink_next;
  logic                   advance;
  logic                   store_req;
  logic signed [63:0]     off_ext;
  rstt_pkg::slot_req_t    req;
  rstt_pkg::slot_stat_t   stat;
  rstt_pkg::result_t      res;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;
  assign off_ext  = 64'(stack_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_kind   <= op_kind;
      q_dst    <= dest_reg;
      q_s1     <= first_src_reg;
      q_s2     <= second_src_reg;
      q_off    <= off_ext[OFFSET_BITS-1:0];
      q_is_src <= call_is_source;
      q_start  <= start_of_run;
    end
  end

  always_comb begin
    req.en    = advance;
    req.clear = q_start;
    req.store = store_req;
  end

  rstt_slot_table #(
    .STACK_SLOTS(STACK_SLOTS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_slots (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .offset (q_off),
    .stat   (stat)
  );

  rstt_propagate u_prop (
    .op_kind        (q_kind),
    .dest_reg       (q_dst),
    .first_src_reg  (q_s1),
    .second_src_reg (q_s2),
    .call_is_source (q_is_src),
    .mask_in        (q_start ? 32'd0 : mask),
    .sink_in        (q_start ? 1'b0 : sink),
    .stat           (stat),
    .store_req      (store_req),
    .mask_out       (mask_next),
    .sink_out       (sink_next),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      sink <= 1'b0;
    end else if (advance) begin
      mask <= mask_next;
      sink <= sink_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      activity         <= res.activity;
      event_kind       <= res.event_kind;
      sink_hit         <= res.sink_hit;
      sink_seen        <= sink_next;
      register_taint   <= mask_next;
      any_slot_tainted <= stat.any;
      slot_overflow    <= res.slot_overflow;
    end
  end

`ifndef ASSERT_OFF
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !activity |-> event_kind == rstt_pkg::EV_NONE && !sink_hit && !slot_overflow)
    else $error("quiet result carries an event");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_overflow |-> any_slot_tainted)
    else $error("overflow reported with an empty slot table");

  a_sink_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && sink_hit |-> sink_seen)
    else $error("sink hit without sticky flag");

  a_overflow_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && slot_overflow |-> event_kind == rstt_pkg::EV_STORE)
    else $error("overflow on a non-store event");
`endif

endmodule

>>> tb/sv/taint_tb_pkg.sv
// Transaction types and the scoreboard for the register and stack taint tracker bench.
// The scoreboard predicts every result from the accepted instructions and checks the DUT.
// Depends on rstt_pkg for the operation and event codes.
package taint_tb_pkg;
  import rstt_pkg::*;

  localparam int TABLE_SLOTS = STACK_SLOTS_DEF;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [5:0]  dst;
    logic signed [5:0]  src1;
    logic signed [5:0]  src2;
    logic [15:0]        offset;
    logic               call_src;
    logic               start;
  } lifted_instr_t;

  typedef struct packed {
    logic        activity;
    logic [2:0]  event_kind;
    logic        sink_hit;
    logic        sink_seen;
    logic [31:0] reg_taint;
    logic        any_slot;
    logic        overflow;
  } taint_report_t;

  class taint_scoreboard;
    logic [31:0]            taint_mask;
    logic [15:0]            slot_off [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_used;
    logic                   sink_latched;
    taint_report_t          pending_reports[$];
    int                     errors;
    int                     n_accepted;
    int                     n_checked;
    int                     n_overflow;
    int                     event_hits [8];

    function new();
      taint_mask = '0;
      slot_used = '0;
      sink_latched = 1'b0;
      errors = 0;
      n_accepted = 0;
      n_checked = 0;
      n_overflow = 0;
      foreach (event_hits[i]) event_hits[i] = 0;
    endfunction

    function bit is_tainted(logic signed [5:0] r);
      return !r[5] && taint_mask[r[4:0]];
    endfunction

    function void add_taint(logic signed [5:0] r);
      if (!r[5]) taint_mask[r[4:0]] = 1'b1;
    endfunction

    function int marked_slot(logic [15:0] off);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slot_used[i] && slot_off[i] == off) return i;
      end
      return -1;
    endfunction

    function void note_instr(lifted_instr_t ins);
      taint_report_t r;
      int free_idx;
      r = '0;
      free_idx = -1;
      if (ins.start) begin
        taint_mask = '0;
        slot_used = '0;
        sink_latched = 1'b0;
      end
      case (ins.op)
        OP_CALL: begin
          if (ins.call_src) begin
            add_taint(6'sd0);
            r.activity = 1'b1;
            r.event_kind = EV_SOURCE;
          end
        end
        OP_STORE: begin
          if (is_tainted(ins.dst)) begin
            r.activity = 1'b1;
            r.event_kind = EV_STORE;
            if (marked_slot(ins.offset) < 0) begin
              for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
                if (!slot_used[i]) free_idx = i;
              end
              if (free_idx >= 0) begin
                slot_used[free_idx] = 1'b1;
                slot_off[free_idx] = ins.offset;
              end else begin
                r.overflow = 1'b1;
              end
            end
          end
        end
        OP_LOAD: begin
          if (marked_slot(ins.offset) >= 0) begin
            add_taint(ins.dst);
            r.activity = 1'b1;
            r.event_kind = EV_LOAD;
          end
        end
        OP_ADD, OP_SUB, OP_MOV: begin
          if (!ins.dst[5] && (is_tainted(ins.src1) || is_tainted(ins.src2))) begin
            add_taint(ins.dst);
            r.activity = 1'b1;
            r.event_kind = EV_SPREAD;
          end
        end
        OP_RETURN: begin
          if (taint_mask[0]) begin
            sink_latched = 1'b1;
            r.sink_hit = 1'b1;
            r.activity = 1'b1;
            r.event_kind = EV_SINK;
          end
        end
        OP_OTHER: begin
          if (is_tainted(ins.src1) && !ins.dst[5]) begin
            add_taint(ins.dst);
            r.activity = 1'b1;
            r.event_kind = EV_GENERIC;
          end
        end
        default: begin
        end
      endcase
      r.sink_seen = sink_latched;
      r.reg_taint = taint_mask;
      r.any_slot = |slot_used;
      event_hits[r.event_kind]++;
      if (r.overflow) n_overflow++;
      n_accepted++;
      pending_reports = {pending_reports, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s differs, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(taint_report_t got);
      taint_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result arrived with nothing expected, actual %h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      n_checked++;
      compare_field("activity", 32'(want.activity), 32'(got.activity));
      compare_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
      compare_field("sink_hit", 32'(want.sink_hit), 32'(got.sink_hit));
      compare_field("sink_seen", 32'(want.sink_seen), 32'(got.sink_seen));
      compare_field("register_taint", want.reg_taint, got.reg_taint);
      compare_field("any_slot_tainted", 32'(want.any_slot), 32'(got.any_slot));
      compare_field("slot_overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

endpackage

>>> tb/sv/tb.sv
// Top-level bench for register_stack_taint_tracker: directed instructions, then taint chains,
// single instructions and noise, with random idling on both channels. Depends on rstt_pkg and taint_tb_pkg.
module tb;
  import rstt_pkg::*;
  import taint_tb_pkg::*;

  localparam logic [3:0] OP_UNDEF_TOP = 4'hF;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_OFF_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         op_kind = OP_NOP;
  logic signed [5:0]  dest_reg = '1;
  logic signed [5:0]  first_src_reg = '1;
  logic signed [5:0]  second_src_reg = '1;
  logic signed [15:0] stack_offset = '0;
  logic               call_is_source = 1'b0;
  logic               start_of_run = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               activity;
  logic [2:0]         event_kind;
  logic               sink_hit;
  logic               sink_seen;
  logic [31:0]        register_taint;
  logic               any_slot_tainted;
  logic               slot_overflow;

  logic        hold_off = 1'b0;
  logic [31:0] cyc = '0;
  int          stall_left = 0;
  int          work_items = 0;
  logic [15:0] off_pool [24];

  taint_scoreboard sb = new();

  register_stack_taint_tracker i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op_kind          (op_kind),
    .dest_reg         (dest_reg),
    .first_src_reg    (first_src_reg),
    .second_src_reg   (second_src_reg),
    .stack_offset     (stack_offset),
    .call_is_source   (call_is_source),
    .start_of_run     (start_of_run),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .activity         (activity),
    .event_kind       (event_kind),
    .sink_hit         (sink_hit),
    .sink_seen        (sink_seen),
    .register_taint   (register_taint),
    .any_slot_tainted (any_slot_tainted),
    .slot_overflow    (slot_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic bit calm_phase();
    return cyc[8:7] == 2'b00;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic lifted_instr_t mk(logic [3:0] op, logic signed [5:0] dst,
                                       logic signed [5:0] s1, logic signed [5:0] s2,
                                       logic [15:0] off, logic csrc, logic start);
    lifted_instr_t ins;
    ins.op = op;
    ins.dst = dst;
    ins.src1 = s1;
    ins.src2 = s2;
    ins.offset = off;
    ins.call_src = csrc;
    ins.start = start;
    return ins;
  endfunction

  function automatic logic signed [5:0] pick_reg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      case ($urandom_range(0, 4))
        0: return 6'sd0;
        1: return 6'sd1;
        2: return 6'sd2;
        3: return 6'sd3;
        default: return 6'sd31;
      endcase
    end
    if (r < 90) return 6'($urandom_range(0, 31));
    return 6'($urandom_range(32, 63));
  endfunction

  function automatic logic [15:0] pick_off();
    if ($urandom_range(0, 99) < 85) return off_pool[$urandom_range(0, 23)];
    return 16'($urandom);
  endfunction

  task automatic send_instr(input lifted_instr_t ins);
    int idle;
    idle = calm_phase() ? 0 : idle_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_kind <= ins.op;
    dest_reg <= ins.dst;
    first_src_reg <= ins.src1;
    second_src_reg <= ins.src2;
    stack_offset <= ins.offset;
    call_is_source <= ins.call_src;
    start_of_run <= ins.start;
    do @(posedge clk); while (!in_ready);
    sb.note_instr(ins);
    if (ins.op inside {OP_ADD, OP_SUB, OP_MOV, OP_LOAD, OP_STORE, OP_CALL, OP_RETURN,
                       OP_OTHER}) begin
      work_items++;
    end
  endtask

  task automatic send_chain();
    logic signed [5:0] carrier;
    logic signed [5:0] next_reg;
    logic [15:0] off;
    logic [3:0] spread_ops [4];
    spread_ops = '{OP_ADD, OP_SUB, OP_MOV, OP_OTHER};
    carrier = 6'sd0;
    off = pick_off();
    send_instr(mk(OP_CALL, '1, '1, '1, 16'($urandom), 1'b1,
                  $urandom_range(0, 99) < 5));
    repeat ($urandom_range(1, 4)) begin
      next_reg = pick_reg();
      if ($urandom_range(0, 1) == 1) begin
        send_instr(mk(spread_ops[$urandom_range(0, 3)], next_reg, carrier, pick_reg(),
                      16'($urandom), 1'($urandom), 1'b0));
      end else begin
        send_instr(mk(spread_ops[$urandom_range(0, 2)], next_reg, pick_reg(), carrier,
                      16'($urandom), 1'($urandom), 1'b0));
      end
      if (!next_reg[5]) carrier = next_reg;
    end
    send_instr(mk(OP_STORE, carrier, pick_reg(), pick_reg(), off, 1'($urandom), 1'b0));
    send_instr(mk(OP_LOAD, pick_reg(), pick_reg(), pick_reg(),
                  ($urandom_range(0, 3) == 0) ? pick_off() : off, 1'($urandom), 1'b0));
    if ($urandom_range(0, 1) == 1) begin
      send_instr(mk(OP_RETURN, pick_reg(), pick_reg(), pick_reg(), 16'($urandom),
                    1'($urandom), 1'b0));
    end
  endtask

  task automatic send_single();
    logic [3:0] ops [8];
    ops = '{OP_ADD, OP_SUB, OP_MOV, OP_LOAD, OP_STORE, OP_CALL, OP_RETURN, OP_OTHER};
    send_instr(mk(ops[$urandom_range(0, 7)], pick_reg(), pick_reg(), pick_reg(), pick_off(),
                  1'($urandom), $urandom_range(0, 99) < 2));
  endtask

  task automatic send_noise();
    send_instr(mk(4'($urandom), 6'($urandom), 6'($urandom), 6'($urandom), 16'($urandom),
                  1'($urandom), $urandom_range(0, 99) < 2));
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result({activity, event_kind, sink_hit, sink_seen, register_taint,
                         any_slot_tainted, slot_overflow});
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm_phase() && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
      end
      out_ready <= !hold_off && stall_left == 0;
    end
  end

  initial begin
    do @(posedge clk); while (sb.n_accepted < 400);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #8000000;
    $display("register_stack_taint_tracker: mismatch");
    $finish;
  end

  initial begin
    int r;
    off_pool[0] = 16'h8000;
    off_pool[1] = 16'h7fff;
    off_pool[2] = 16'h0000;
    off_pool[3] = 16'hffff;
    for (int i = 4; i < 24; i++) off_pool[i] = 16'($urandom);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_instr(mk(OP_NOP, '1, '1, '1, 16'h0000, 1'b0, 1'b1));
    send_instr(mk(OP_CALL, 6'sd0, '1, '1, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_BRANCH, 6'sd0, 6'sd0, 6'sd0, 16'h0000, 1'b1, 1'b0));
    send_instr(mk(OP_CALL, '1, '1, '1, 16'h0000, 1'b1, 1'b0));
    send_instr(mk(OP_RETURN, '1, '1, '1, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_STORE, 6'sd0, '1, '1, 16'h8000, 1'b0, 1'b0));
    send_instr(mk(OP_STORE, 6'sd0, '1, '1, 16'h7fff, 1'b0, 1'b0));
    send_instr(mk(OP_STORE, 6'sd0, '1, '1, 16'h7fff, 1'b0, 1'b0));
    send_instr(mk(OP_LOAD, 6'sd31, '1, '1, 16'h8000, 1'b0, 1'b0));
    send_instr(mk(OP_LOAD, '1, '1, '1, 16'h7fff, 1'b0, 1'b0));
    send_instr(mk(OP_MOV, 6'sd30, 6'sd31, -6'sd32, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_ADD, 6'sd7, '1, 6'sd30, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_SUB, -6'sd2, 6'sd0, 6'sd0, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_OTHER, 6'sd8, 6'sd7, '1, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_OTHER, 6'sd9, '1, 6'sd8, 16'h0000, 1'b0, 1'b0));
    send_instr(mk(OP_CBNZ, 6'sd1, 6'sd0, 6'sd0, 16'hffff, 1'b1, 1'b0));
    send_instr(mk(OP_UNDEF_TOP, 6'sd1, 6'sd0, 6'sd0, 16'hffff, 1'b1, 1'b0));
    for (int k = 0; k < TABLE_SLOTS - 2; k++) begin
      send_instr(mk(OP_STORE, 6'sd0, '1, '1, 16'h0100 + 16'(k), 1'b0, 1'b0));
    end
    send_instr(mk(OP_STORE, 6'sd7, '1, '1, 16'h0200, 1'b0, 1'b0));
    send_instr(mk(OP_RETURN, '1, '1, '1, 16'h0000, 1'b0, 1'b1));

    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_chain();
      else if (r < 80) send_single();
      else send_noise();
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d of %0d instructions; events source %0d, store %0d, load %0d,",
             sb.n_checked, sb.n_accepted, sb.event_hits[EV_SOURCE], sb.event_hits[EV_STORE],
             sb.event_hits[EV_LOAD]);
    $display("spread %0d, sink %0d, generic %0d; offset table overflowed %0d times.",
             sb.event_hits[EV_SPREAD], sb.event_hits[EV_SINK], sb.event_hits[EV_GENERIC],
             sb.n_overflow);
    if (sb.errors == 0) begin
      $display("register_stack_taint_tracker: match");
    end else begin
      $display("register_stack_taint_tracker: mismatch");
    end
    $finish;
  end

endmodule
